/* hw/rtl/tfn_pkg.sv */
package tfn_pkg;

   localparam int VERTEX_SLOTS = 1024;
   localparam int SLOT_ADDR_W = $clog2(VERTEX_SLOTS);
   localparam int SLOT_W = 10;
   localparam int COORD_W = 16;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int NORMAL_W = PROD_W + 1;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_FIELDS_W = 3 * COORD_W + 3 * NORMAL_W;
   localparam int RSP_DATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic {
      OP_WRITE    = 1'b0,
      OP_TRIANGLE = 1'b1
   } op_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } pos_type;

   localparam int POS_W = $bits(pos_type);

   typedef logic [SLOT_ADDR_W-1:0] slot_addr_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
      pos_type           pos;
      logic [SLOT_W-1:0] corner_a;
      logic [SLOT_W-1:0] corner_b;
      logic [SLOT_W-1:0] corner_c;
   } cmd_type;

   function automatic logic slot_in_store(logic [SLOT_W-1:0] s);
      return 32'(s) < VERTEX_SLOTS;
   endfunction

   function automatic slot_addr_type slot_addr(logic [SLOT_W-1:0] s);
      return SLOT_ADDR_W'(s);
   endfunction

endpackage

/* hw/rtl/tfn_ram.sv */
module tfn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tfn_front.sv */
module tfn_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tfn_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,
   output tfn_pkg::cmd_type                   head,
   output logic                               head_valid,
   input  logic                               head_pop
);

   import tfn_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd;
   logic                push;
   logic                pop;

   always_comb begin
      cmd.op       = req_tuser ? OP_TRIANGLE : OP_WRITE;
      cmd.slot     = req_tdata[9:0];
      cmd.pos.x    = req_tdata[25:10];
      cmd.pos.y    = req_tdata[41:26];
      cmd.pos.z    = req_tdata[57:42];
      cmd.corner_a = req_tdata[67:58];
      cmd.corner_b = req_tdata[77:68];
      cmd.corner_c = req_tdata[87:78];
   end

   assign req_tready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

/* hw/rtl/tfn_back.sv */
module tfn_back (
   input  logic                           clock,
   input  logic                           reset,
   input  tfn_pkg::cmd_type               head,
   input  logic                           head_valid,
   output logic                           head_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tfn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   import tfn_pkg::*;

   typedef enum logic [1:0] {
      PH_A = 2'd0,
      PH_B = 2'd1,
      PH_C = 2'd2
   } phase_type;

   logic                       adv;
   phase_type                  ph_ff, ph_in;
   logic [SLOT_W-1:0]          rd_slot;
   logic                       wr_en;
   logic                       rd_issue;
   pos_type                    rd_data;
   pos_type                    fetched;

   logic                       v1_ff;
   phase_type                  ph1_ff;
   logic                       zero1_ff;

   pos_type                    p1_ff, p2_ff;

   logic                       v2_ff;
   pos_type                    c1_ff, c2_ff, c3_ff;
   logic signed [DIFF_W-1:0]   ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;

   logic                       v3_ff;
   pos_type                    d1_ff, d2_ff, d3_ff;
   logic signed [PROD_W-1:0]   m_ff [6];

   logic signed [NORMAL_W-1:0] nx_in, ny_in, nz_in;

   logic                       ob_valid_ff;
   logic [1:0]                 ob_cnt_ff;
   pos_type                    ob_p_ff [3];
   logic signed [NORMAL_W-1:0] ob_nx_ff, ob_ny_ff, ob_nz_ff;
   logic                       ob_free;
   logic                       rsp_take;
   pos_type                    ob_pos;

   assign rsp_take = rsp_tvalid && rsp_tready;
   assign ob_free  = !ob_valid_ff || (rsp_tready && ob_cnt_ff == PH_C);
   assign adv      = !v3_ff || ob_free;

   always_comb begin
      unique case (ph_ff)
         PH_A:    rd_slot = head.corner_a;
         PH_B:    rd_slot = head.corner_b;
         default: rd_slot = head.corner_c;
      endcase
   end

   assign rd_issue = adv && head_valid && head.op == OP_TRIANGLE;
   assign wr_en    = adv && head_valid && head.op == OP_WRITE && slot_in_store(head.slot);
   assign head_pop = adv && head_valid && (head.op == OP_WRITE || ph_ff == PH_C);

   always_comb begin
      ph_in = ph_ff;
      if (rd_issue) begin
         ph_in = (ph_ff == PH_C) ? PH_A : phase_type'(ph_ff + 2'd1);
      end
   end

   tfn_ram #(
      .WIDTH (POS_W),
      .DEPTH (VERTEX_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_addr(head.slot)),
      .wr_data (head.pos),
      .rd_en   (adv),
      .rd_addr (slot_addr(rd_slot)),
      .rd_data (rd_data)
   );

   assign fetched = zero1_ff ? '0 : rd_data;

   assign nx_in = NORMAL_W'(m_ff[0]) - NORMAL_W'(m_ff[1]);
   assign ny_in = NORMAL_W'(m_ff[2]) - NORMAL_W'(m_ff[3]);
   assign nz_in = NORMAL_W'(m_ff[4]) - NORMAL_W'(m_ff[5]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff       <= PH_A;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         ob_valid_ff <= 1'b0;
         ob_cnt_ff   <= PH_A;
      end else begin
         ph_ff <= ph_in;
         if (adv) begin
            v1_ff <= rd_issue;
            v2_ff <= v1_ff && ph1_ff == PH_C;
            v3_ff <= v2_ff;
         end
         if (v3_ff && adv) begin
            ob_valid_ff <= 1'b1;
            ob_cnt_ff   <= PH_A;
         end else if (rsp_take) begin
            if (ob_cnt_ff == PH_C) begin
               ob_valid_ff <= 1'b0;
               ob_cnt_ff   <= PH_A;
            end else begin
               ob_cnt_ff <= ob_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph1_ff   <= ph_ff;
         zero1_ff <= !slot_in_store(rd_slot);
         if (v1_ff && ph1_ff == PH_A) begin
            p1_ff <= fetched;
         end
         if (v1_ff && ph1_ff == PH_B) begin
            p2_ff <= fetched;
         end
         c1_ff <= p1_ff;
         c2_ff <= p2_ff;
         c3_ff <= fetched;
         ux_ff <= DIFF_W'(p2_ff.x) - DIFF_W'(fetched.x);
         uy_ff <= DIFF_W'(p2_ff.y) - DIFF_W'(fetched.y);
         uz_ff <= DIFF_W'(p2_ff.z) - DIFF_W'(fetched.z);
         vx_ff <= DIFF_W'(fetched.x) - DIFF_W'(p1_ff.x);
         vy_ff <= DIFF_W'(fetched.y) - DIFF_W'(p1_ff.y);
         vz_ff <= DIFF_W'(fetched.z) - DIFF_W'(p1_ff.z);
         d1_ff   <= c1_ff;
         d2_ff   <= c2_ff;
         d3_ff   <= c3_ff;
         m_ff[0] <= uy_ff * vz_ff;
         m_ff[1] <= uz_ff * vy_ff;
         m_ff[2] <= uz_ff * vx_ff;
         m_ff[3] <= ux_ff * vz_ff;
         m_ff[4] <= ux_ff * vy_ff;
         m_ff[5] <= uy_ff * vx_ff;
      end
      if (v3_ff && adv) begin
         ob_p_ff[0] <= d1_ff;
         ob_p_ff[1] <= d2_ff;
         ob_p_ff[2] <= d3_ff;
         ob_nx_ff   <= nx_in;
         ob_ny_ff   <= ny_in;
         ob_nz_ff   <= nz_in;
      end
   end

   always_comb begin
      unique case (ob_cnt_ff)
         PH_A:    ob_pos = ob_p_ff[0];
         PH_B:    ob_pos = ob_p_ff[1];
         default: ob_pos = ob_p_ff[2];
      endcase
   end

   assign rsp_tvalid = ob_valid_ff;
   assign rsp_tlast  = ob_cnt_ff == PH_C;
   assign rsp_tdata  = RSP_DATA_W'({ob_nz_ff, ob_ny_ff, ob_nx_ff, ob_pos.z, ob_pos.y, ob_pos.x});

endmodule

/* hw/rtl/triangle_face_normal.sv */
// Triangle face normal unit. A write item (req_tuser low) stores one signed Q8.8 position
// into a slot of a 1024-entry vertex memory and gives no result. A triangle item (req_tuser
// high) reads its three corner slots through the single read port of that memory, one per
// cycle while the result output is not stalled, and emits three result items. Each result
// carries one corner (p1, p2, p3 in that order) and the exact Q19.16 normal (p2 - p3) x
// (p3 - p1); the third is marked by rsp_tlast. A four-entry command queue decouples input
// acceptance from the back end. Slots never written read as undefined data. The memory
// needs no clearing after reset.
module triangle_face_normal (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // vertex_slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
   input  logic [tfn_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_x, out_y, out_z, normal_x, normal_y, normal_z, zero fill
   output logic [tfn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   import tfn_pkg::*;

   cmd_type head;
   logic    head_valid;
   logic    head_pop;

   tfn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   tfn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hw/rtl/tfn_checker.sv */
module tfn_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tfn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   import tfn_pkg::*;

   localparam int NORM_LO = 3 * COORD_W;
   localparam int NORM_HI = 3 * COORD_W + 3 * NORMAL_W - 1;

   logic [1:0] seen_ff;
   logic [7:0] owed_ff, owed_in;
   logic       rsp_take;
   logic       req_take;

   assign rsp_take = rsp_tvalid && rsp_tready;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      owed_in = owed_ff;
      if (req_take && req_tuser) begin
         owed_in = owed_in + 8'd3;
      end
      if (rsp_take) begin
         owed_in = owed_in - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
         owed_ff <= 8'd0;
      end else begin
         owed_ff <= owed_in;
         if (rsp_take) begin
            seen_ff <= rsp_tlast ? 2'd0 : seen_ff + 2'd1;
         end
      end
   end

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item shown straight after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_tlast == (seen_ff == 2'd2)))
      else $error("last corner not on every third result item");

   assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_tlast |=> rsp_tvalid && $stable(rsp_tdata[NORM_HI:NORM_LO]))
      else $error("normal changed within one triangle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> owed_ff != 8'd0)
      else $error("result item with no triangle owed");

endmodule

bind triangle_face_normal tfn_checker u_checker (.*);
